// ===== src/ctbt_pkg.sv =====
`default_nettype none

package ctbt_pkg;

    // Fixed field widths of the channels.
    localparam int RAW_W     = 10;
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_GAIN = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] GUARD_TIME_RST = 16'd1000;
    localparam logic [CFG_W-1:0] TRACK_RATE_RST = 16'd66;
    localparam logic [CFG_W-1:0] TOUCH_GAIN_RST = 16'd164;

    // Fractional bits of the baseline and rounding constant for Q.16 products.
    localparam int FRAC_W = 16;
    localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;
    localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

    // Which kind of result the item in flight produces.
    typedef enum logic [1:0] {
        KIND_WARM  = 2'd0,
        KIND_REUSE = 2'd1,
        KIND_TRACK = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_last;
        logic prod;
        logic base;
        logic scale;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic warm;
        logic warm_last;
        logic blocked;
        logic slot_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/ctbt_if.sv =====
`default_nettype none

interface ctbt_sample_if;
    logic                         valid;
    logic                         ready;
    logic [ctbt_pkg::RAW_W-1:0]   raw_sample;
    logic [ctbt_pkg::TIME_W-1:0]  time_us;

    modport source (output valid, output raw_sample, output time_us, input ready);
    modport sink   (input valid, input raw_sample, input time_us, output ready);
endinterface

interface ctbt_result_if;
    logic                          valid;
    logic                          ready;
    logic [ctbt_pkg::LEVEL_W-1:0]  touch_level;
    logic [ctbt_pkg::TIME_W-1:0]   sample_time;
    logic                          reused;
    logic                          warming_up;

    modport source (output valid, output touch_level, output sample_time,
                    output reused, output warming_up, input ready);
    modport sink   (input valid, input touch_level, input sample_time,
                    input reused, input warming_up, output ready);
endinterface

interface ctbt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ctbt_pkg::CFG_IDX_W-1:0]  index;
    logic [ctbt_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ctbt_ctrl.sv =====
`default_nettype none

module ctbt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ctbt_pkg::status_t st,
    output ctbt_pkg::cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_PROD  = 6'b000100,
        S_BASE  = 6'b001000,
        S_SCALE = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (st.warm)
                    begin
                        if (st.warm_last)
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (st.blocked)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PROD;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_last = 1'b1;
                state_next   = S_FIN;
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Wait here until the output register can take the result.
                if (st.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ctbt_datapath.sv =====
`default_nettype none

module ctbt_datapath #(
    parameter int WARMUP_SAMPLES = 16,
    parameter int SAMPLE_BITS    = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ctbt_pkg::RAW_W-1:0]    raw_sample,
    input  wire logic [ctbt_pkg::TIME_W-1:0]   time_us,
    input  wire ctbt_pkg::cmd_t                cmd,
    output ctbt_pkg::status_t                  st,
    ctbt_cfg_if.sink                           cfg,
    ctbt_result_if.source                      result
);

    localparam int FW    = ctbt_pkg::FRAC_W;
    localparam int BW    = SAMPLE_BITS + FW;
    localparam int CW    = $clog2(WARMUP_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WARMUP_SAMPLES + 1);
    // The warm-up mean floor(sum * 2^FW / WARMUP_SAMPLES) is formed as
    // (sum * RECIP) >> RS_W; RK is large enough for the product to be exact.
    localparam int RS_W  = SUM_W + $clog2(WARMUP_SAMPLES) + 1;
    localparam int RK    = RS_W + FW;
    localparam int RC_W  = RK - $clog2(WARMUP_SAMPLES) + 1;
    localparam int MP_W  = SUM_W + RC_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RK) + 64'(WARMUP_SAMPLES) - 64'd1) / 64'(WARMUP_SAMPLES);
    localparam int P1_W  = BW + FW + 1;
    localparam int P2_W  = SAMPLE_BITS + ctbt_pkg::CFG_W;
    localparam int ACC_W = BW + FW + 2;
    localparam int SC_W  = BW + ctbt_pkg::CFG_W;
    localparam int LV_W  = SC_W + 1;

    // Configuration registers.
    logic [ctbt_pkg::CFG_W-1:0]   guard_reg, rate_reg, gain_reg;

    // Tracker state.
    logic [BW-1:0]                baseline_reg;
    logic [CW-1:0]                wcount_reg;
    logic [SUM_W-1:0]             wsum_reg;
    logic [ctbt_pkg::TIME_W-1:0]  last_time_reg;
    logic [ctbt_pkg::LEVEL_W-1:0] last_level_reg;

    // Item in flight.
    logic [SAMPLE_BITS-1:0]       raw_reg;
    logic [ctbt_pkg::TIME_W-1:0]  time_reg;
    ctbt_pkg::kind_t              kind_reg;

    // Tracking and scaling products.
    logic [P1_W-1:0]              p1_reg;
    logic [P2_W-1:0]              p2_reg;
    logic [SC_W-1:0]              sc_reg;
    logic                         pos_reg;

    // Output register.
    logic                         out_valid_reg;
    logic [ctbt_pkg::LEVEL_W-1:0] out_level_reg;
    logic [ctbt_pkg::TIME_W-1:0]  out_time_reg;
    logic                         out_reused_reg;
    logic                         out_warm_reg;

    logic [SAMPLE_BITS-1:0]       raw_in;
    logic [SUM_W-1:0]             wsum_next;
    logic [ctbt_pkg::TIME_W-1:0]  elapsed;
    logic [MP_W-1:0]              mean_prod;
    logic [FW:0]                  keep_w;
    logic [P1_W-1:0]              p1_next;
    logic [P2_W-1:0]              p2_next;
    logic [ACC_W-1:0]             acc;
    logic [BW-1:0]                base_next;
    logic [BW-1:0]                sample_q16;
    logic                         pos_next;
    logic [BW-1:0]                diff;
    logic [SC_W-1:0]              sc_next;
    logic [LV_W-1:0]              lv_sum;
    logic [ctbt_pkg::LEVEL_W-1:0] level;

    generate
        if (SAMPLE_BITS <= ctbt_pkg::RAW_W)
        begin : g_raw_cut
            assign raw_in = raw_sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_raw_ext
            assign raw_in = {{(SAMPLE_BITS - ctbt_pkg::RAW_W){1'b0}}, raw_sample};
        end
    endgenerate

    assign wsum_next = wsum_reg + SUM_W'(raw_in);
    assign elapsed   = time_us - last_time_reg;

    assign st.warm      = (wcount_reg < CW'(WARMUP_SAMPLES));
    assign st.warm_last = (wcount_reg == CW'(WARMUP_SAMPLES - 1));
    assign st.blocked   = (elapsed < ctbt_pkg::TIME_W'(guard_reg));
    assign st.slot_free = !out_valid_reg || result.ready;

    assign mean_prod = MP_W'(wsum_reg) * MP_W'(RECIP);

    // New baseline = ((1 - r) * baseline + r * sample) in Q.16, rounded.
    assign keep_w    = ctbt_pkg::ONE_Q16 - (FW + 1)'(rate_reg);
    assign p1_next   = P1_W'(keep_w) * P1_W'(baseline_reg);
    assign p2_next   = P2_W'(rate_reg) * P2_W'(raw_reg);
    assign acc       = ACC_W'(p1_reg) + ACC_W'({p2_reg, {FW{1'b0}}})
                     + ACC_W'(ctbt_pkg::HALF_Q16);
    assign base_next = acc[BW+FW-1:FW];

    assign sample_q16 = {raw_reg, {FW{1'b0}}};
    assign pos_next   = (sample_q16 > baseline_reg);
    assign diff       = sample_q16 - baseline_reg;
    assign sc_next    = SC_W'(diff) * SC_W'(gain_reg);
    assign lv_sum     = LV_W'(sc_reg) + LV_W'(ctbt_pkg::HALF_Q16);

    always_comb
    begin
        if (!pos_reg)
        begin
            level = '0;
        end
        else if (lv_sum[LV_W-1:FW] > (LV_W - FW)'(ctbt_pkg::LEVEL_MAX))
        begin
            level = ctbt_pkg::LEVEL_MAX;
        end
        else
        begin
            level = lv_sum[FW+ctbt_pkg::LEVEL_W-1:FW];
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg <= ctbt_pkg::GUARD_TIME_RST;
            rate_reg  <= ctbt_pkg::TRACK_RATE_RST;
            gain_reg  <= ctbt_pkg::TOUCH_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ctbt_pkg::REG_GUARD_TIME: guard_reg <= cfg.data;
                ctbt_pkg::REG_TRACK_RATE: rate_reg  <= cfg.data;
                ctbt_pkg::REG_TOUCH_GAIN: gain_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= '0;
            wcount_reg     <= '0;
            wsum_reg       <= '0;
            last_time_reg  <= '0;
            last_level_reg <= '0;
            kind_reg       <= ctbt_pkg::KIND_WARM;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                if (st.warm)
                begin
                    kind_reg   <= ctbt_pkg::KIND_WARM;
                    wsum_reg   <= wsum_next;
                    wcount_reg <= wcount_reg + 1'b1;
                end
                else if (st.blocked)
                begin
                    kind_reg <= ctbt_pkg::KIND_REUSE;
                end
                else
                begin
                    kind_reg <= ctbt_pkg::KIND_TRACK;
                end
            end
            if (cmd.div_last)
            begin
                baseline_reg <= mean_prod[RS_W+BW-1:RS_W];
            end
            if (cmd.base)
            begin
                baseline_reg <= base_next;
            end
            if (cmd.finish && kind_reg == ctbt_pkg::KIND_TRACK)
            begin
                last_level_reg <= level;
                last_time_reg  <= time_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg  <= raw_in;
            time_reg <= time_us;
        end
        if (cmd.prod)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (cmd.scale)
        begin
            sc_reg  <= sc_next;
            pos_reg <= pos_next;
        end
        if (cmd.finish)
        begin
            case (kind_reg)
                ctbt_pkg::KIND_WARM:
                begin
                    out_level_reg  <= '0;
                    out_time_reg   <= time_reg;
                    out_reused_reg <= 1'b0;
                    out_warm_reg   <= 1'b1;
                end
                ctbt_pkg::KIND_REUSE:
                begin
                    out_level_reg  <= last_level_reg;
                    out_time_reg   <= last_time_reg;
                    out_reused_reg <= 1'b1;
                    out_warm_reg   <= 1'b0;
                end
                ctbt_pkg::KIND_TRACK:
                begin
                    out_level_reg  <= level;
                    out_time_reg   <= time_reg;
                    out_reused_reg <= 1'b0;
                    out_warm_reg   <= 1'b0;
                end
                default:
                begin
                    out_level_reg  <= '0;
                    out_time_reg   <= '0;
                    out_reused_reg <= 1'b0;
                    out_warm_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.touch_level = out_level_reg;
    assign result.sample_time = out_time_reg;
    assign result.reused      = out_reused_reg;
    assign result.warming_up  = out_warm_reg;

endmodule

`default_nettype wire

// ===== src/capacitive_touch_baseline_tracker_core.sv =====
`default_nettype none

// Capacitive touch baseline tracker. Each pad sample yields one result item.
// The first WARMUP_SAMPLES items build the baseline from their mean and report
// warming_up; later items either reuse the previous level (guard time not yet
// passed) or move the baseline by an exponential average and report the gain-
// scaled excess of the sample over it. One item is worked on at a time: warm-up
// and reused items go from capture straight to the output step; tracked items
// pass through a multiply step for the two weighted products, one for the add,
// one for the gain multiply and one to saturate and load the output register.
// The item that completes warm-up has an extra step, a multiply of the sum
// by a constant reciprocal of WARMUP_SAMPLES that forms the mean. A finished
// result waits in the output register while the next item is taken in; that
// item then waits in its last step for as long as the output register stays
// full. Configuration writes are accepted in every cycle.
module capacitive_touch_baseline_tracker_core #(
    parameter int WARMUP_SAMPLES = 16,
    parameter int SAMPLE_BITS    = 10
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ctbt_sample_if.sink    sample,
    ctbt_result_if.source  result,
    ctbt_cfg_if.sink       cfg
);

    ctbt_pkg::cmd_t    cmd;
    ctbt_pkg::status_t st;
    logic              ready;

    assign sample.ready = ready;

    ctbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    ctbt_datapath #(
        .WARMUP_SAMPLES (WARMUP_SAMPLES),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_sample (sample.raw_sample),
        .time_us    (sample.time_us),
        .cmd        (cmd),
        .st         (st),
        .cfg        (cfg),
        .result     (result)
    );

endmodule

`default_nettype wire
